FILE: sv/ltrk_pkg.sv
// ----------------------------------------------------------------------------
// ltrk_pkg
// shared constants and types for the two-axis light tracker servo loop
// ----------------------------------------------------------------------------
package ltrk_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF    = 10;
   localparam int GAIN_FRAC_BITS_DEF = 12;

   // fixed field widths
   localparam int GAIN_W      = 16;
   localparam int DZ_W        = 8;
   localparam int POS_W       = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_TDATA_W = ((2 * POS_W + 7) / 8) * 8;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_INVERT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_INVERT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN    = 3'd6;

   // register reset values
   localparam logic [GAIN_W-1:0] YAW_GAIN_RST     = 16'd492;
   localparam logic [GAIN_W-1:0] PITCH_GAIN_RST   = 16'd205;
   localparam logic              YAW_INVERT_RST   = 1'b0;
   localparam logic              PITCH_INVERT_RST = 1'b1;
   localparam logic [DZ_W-1:0]   DEAD_ZONE_RST    = 8'd0;
   localparam logic [POS_W-1:0]  PULSE_MAX_RST    = 12'd1900;
   localparam logic [POS_W-1:0]  PULSE_MIN_RST    = 12'd1100;

   // position reset values
   localparam logic [POS_W-1:0] YAW_POS_RST   = 12'd1500;
   localparam logic [POS_W-1:0] PITCH_POS_RST = 12'd1750;

   // qualifiers of one axis step
   typedef struct packed {
      logic neg;    // exact step below zero
      logic pos;    // exact step above zero
      logic drop;   // magnitude inside the dead zone
   } step_flags_type;

endpackage

FILE: sv/two_axis_light_tracker_servo_loop_top.sv
// ----------------------------------------------------------------------------
// two_axis_light_tracker_servo_loop_top
// light-seeking pan/tilt servo loop: four sensor samples in, two pulse widths out
// ----------------------------------------------------------------------------
// Each transfer on the req side carries one control tick of four light samples;
// the block answers with exactly one rsp transfer holding the new yaw and pitch
// servo pulse widths in microseconds. Yaw error is right minus left, pitch error
// is top minus bottom; each is negated, scaled by its unsigned gain
// (GAIN_FRAC_BITS fractional bits), optionally inverted, and integrated into a
// 12-bit position saturated to 0..4095. Steps under the dead zone, and steps that
// push outward while the axis sits at or past pulse_min/pulse_max, are dropped;
// an accepted step may overshoot a limit. The block takes one item per clock
// while rsp_tready does not stall the output, through a three-register pipeline
// (input register, gain product register, position register); rsp_tvalid rises
// as a result is loaded into the position register, which feeds back on itself
// so that a new item may follow on every clock. The csr port is always ready;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
module two_axis_light_tracker_servo_loop_top #(
   parameter int SAMPLE_BITS    = ltrk_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = ltrk_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: light_top_right, light_top_left, light_bottom_right,
   // light_bottom_left, zero padding
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: yaw_pulse, pitch_pulse
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [ltrk_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ltrk_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ltrk_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int MAG_W = ltrk_pkg::GAIN_W + SAMPLE_BITS + 1;
   localparam int POS_W = ltrk_pkg::POS_W;

   // configuration registers
   logic [ltrk_pkg::GAIN_W-1:0] yaw_gain_ff;
   logic [ltrk_pkg::GAIN_W-1:0] pitch_gain_ff;
   logic                        yaw_invert_ff;
   logic                        pitch_invert_ff;
   logic [ltrk_pkg::DZ_W-1:0]   dead_zone_ff;
   logic [POS_W-1:0]            pulse_max_ff;
   logic [POS_W-1:0]            pulse_min_ff;

   // pipeline valids
   logic in_vld_ff;
   logic in_vld_in;
   logic prod_vld_ff;
   logic prod_vld_in;
   logic rsp_vld_ff;
   logic rsp_vld_in;

   // stage loads, each stage moves on when its successor has room
   logic out_load;
   logic prod_load;
   logic in_load;

   // input register
   logic [SAMPLE_BITS-1:0] top_right_ff;
   logic [SAMPLE_BITS-1:0] top_left_ff;
   logic [SAMPLE_BITS-1:0] bot_right_ff;
   logic [SAMPLE_BITS-1:0] bot_left_ff;

   // product stage outputs
   logic [MAG_W-1:0]          yaw_mag;
   logic [MAG_W-1:0]          pitch_mag;
   ltrk_pkg::step_flags_type  yaw_flags;
   ltrk_pkg::step_flags_type  pitch_flags;

   // positions double as the result register
   logic [POS_W-1:0] yaw_pos;
   logic [POS_W-1:0] pitch_pos;

   assign csr_ready = 1'b1;

   always_comb begin
      out_load    = !rsp_vld_ff || rsp_tready;
      prod_load   = !prod_vld_ff || out_load;
      in_load     = !in_vld_ff || prod_load;
      in_vld_in   = in_load   ? req_tvalid  : in_vld_ff;
      prod_vld_in = prod_load ? in_vld_ff   : prod_vld_ff;
      rsp_vld_in  = out_load  ? prod_vld_ff : rsp_vld_ff;
   end

   assign req_tready = in_load;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {pitch_pos, yaw_pos};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // sample capture on each req transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && in_load) begin
         top_right_ff <= req_tdata[SAMPLE_BITS-1:0];
         top_left_ff  <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         bot_right_ff <= req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
         bot_left_ff  <= req_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
      end
   end

   // register file; indexes past the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_gain_ff     <= ltrk_pkg::YAW_GAIN_RST;
         pitch_gain_ff   <= ltrk_pkg::PITCH_GAIN_RST;
         yaw_invert_ff   <= ltrk_pkg::YAW_INVERT_RST;
         pitch_invert_ff <= ltrk_pkg::PITCH_INVERT_RST;
         dead_zone_ff    <= ltrk_pkg::DEAD_ZONE_RST;
         pulse_max_ff    <= ltrk_pkg::PULSE_MAX_RST;
         pulse_min_ff    <= ltrk_pkg::PULSE_MIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            ltrk_pkg::CSR_YAW_GAIN: begin
               yaw_gain_ff <= csr_wdata;
            end
            ltrk_pkg::CSR_PITCH_GAIN: begin
               pitch_gain_ff <= csr_wdata;
            end
            ltrk_pkg::CSR_YAW_INVERT: begin
               yaw_invert_ff <= csr_wdata[0];
            end
            ltrk_pkg::CSR_PITCH_INVERT: begin
               pitch_invert_ff <= csr_wdata[0];
            end
            ltrk_pkg::CSR_DEAD_ZONE: begin
               dead_zone_ff <= csr_wdata[ltrk_pkg::DZ_W-1:0];
            end
            ltrk_pkg::CSR_PULSE_MAX: begin
               pulse_max_ff <= csr_wdata[POS_W-1:0];
            end
            ltrk_pkg::CSR_PULSE_MIN: begin
               pulse_min_ff <= csr_wdata[POS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // yaw: right minus left
   ltrk_step_calc #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_yaw_calc (
      .clock     (clock),
      .load      (prod_load && in_vld_ff),
      .plus_a    (top_right_ff),
      .plus_b    (bot_right_ff),
      .minus_a   (top_left_ff),
      .minus_b   (bot_left_ff),
      .gain      (yaw_gain_ff),
      .invert    (yaw_invert_ff),
      .dead_zone (dead_zone_ff),
      .mag_ff    (yaw_mag),
      .flags_ff  (yaw_flags)
   );

   // pitch: top minus bottom
   ltrk_step_calc #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_pitch_calc (
      .clock     (clock),
      .load      (prod_load && in_vld_ff),
      .plus_a    (top_right_ff),
      .plus_b    (top_left_ff),
      .minus_a   (bot_right_ff),
      .minus_b   (bot_left_ff),
      .gain      (pitch_gain_ff),
      .invert    (pitch_invert_ff),
      .dead_zone (dead_zone_ff),
      .mag_ff    (pitch_mag),
      .flags_ff  (pitch_flags)
   );

   // positions advance only as a result enters the output slot
   ltrk_axis #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .RESET_POS      (ltrk_pkg::YAW_POS_RST)
   ) u_yaw_axis (
      .clock       (clock),
      .reset       (reset),
      .update      (out_load && prod_vld_ff),
      .mag         (yaw_mag),
      .flags       (yaw_flags),
      .pulse_min   (pulse_min_ff),
      .pulse_max   (pulse_max_ff),
      .position_ff (yaw_pos)
   );

   ltrk_axis #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .RESET_POS      (ltrk_pkg::PITCH_POS_RST)
   ) u_pitch_axis (
      .clock       (clock),
      .reset       (reset),
      .update      (out_load && prod_vld_ff),
      .mag         (pitch_mag),
      .flags       (pitch_flags),
      .pulse_min   (pulse_min_ff),
      .pulse_max   (pulse_max_ff),
      .position_ff (pitch_pos)
   );

endmodule

FILE: sv/ltrk_step_calc.sv
// ----------------------------------------------------------------------------
// ltrk_step_calc
// error, gain product and step qualifiers of one axis, registered
// ----------------------------------------------------------------------------
module ltrk_step_calc #(
   parameter int SAMPLE_BITS    = ltrk_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = ltrk_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           load,
   input  logic [SAMPLE_BITS-1:0]                         plus_a,
   input  logic [SAMPLE_BITS-1:0]                         plus_b,
   input  logic [SAMPLE_BITS-1:0]                         minus_a,
   input  logic [SAMPLE_BITS-1:0]                         minus_b,
   input  logic [ltrk_pkg::GAIN_W-1:0]                    gain,
   input  logic                                           invert,
   input  logic [ltrk_pkg::DZ_W-1:0]                      dead_zone,
   output logic [ltrk_pkg::GAIN_W+SAMPLE_BITS:0]          mag_ff,
   output ltrk_pkg::step_flags_type                       flags_ff
);

   localparam int SUM_W = SAMPLE_BITS + 1;
   localparam int ERR_W = SAMPLE_BITS + 2;
   localparam int ABS_W = SAMPLE_BITS + 1;
   localparam int MAG_W = ltrk_pkg::GAIN_W + ABS_W;

   logic [SUM_W-1:0]          sum_plus;
   logic [SUM_W-1:0]          sum_minus;
   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          err_abs;
   logic                      err_neg;
   logic                      err_pos;
   logic [MAG_W-1:0]          mag_in;
   logic [MAG_W-1:0]          dz_limit;
   logic                      mag_nz;
   ltrk_pkg::step_flags_type  flags_in;

   always_comb begin
      sum_plus  = SUM_W'(plus_a) + SUM_W'(plus_b);
      sum_minus = SUM_W'(minus_a) + SUM_W'(minus_b);
      err       = $signed(ERR_W'(sum_plus)) - $signed(ERR_W'(sum_minus));
      err_neg   = err[ERR_W-1];
      err_pos   = !err_neg && (err != '0);
      err_abs   = err_neg ? ERR_W'(-err) : ERR_W'(err);
      mag_in    = MAG_W'(gain) * MAG_W'(err_abs[ABS_W-1:0]);
      mag_nz    = (mag_in != '0);
      dz_limit  = MAG_W'(dead_zone) << GAIN_FRAC_BITS;
      // step is -gain*err, negated once more when inverted
      flags_in.neg  = mag_nz && ((err_pos && !invert) || (err_neg && invert));
      flags_in.pos  = mag_nz && ((err_neg && !invert) || (err_pos && invert));
      flags_in.drop = (mag_in < dz_limit);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff   <= mag_in;
         flags_ff <= flags_in;
      end
   end

endmodule

FILE: sv/ltrk_axis.sv
// ----------------------------------------------------------------------------
// ltrk_axis
// position register of one axis with limit rules and saturating update
// ----------------------------------------------------------------------------
module ltrk_axis #(
   parameter int                          SAMPLE_BITS    = ltrk_pkg::SAMPLE_BITS_DEF,
   parameter int                          GAIN_FRAC_BITS = ltrk_pkg::GAIN_FRAC_BITS_DEF,
   parameter logic [ltrk_pkg::POS_W-1:0]  RESET_POS      = ltrk_pkg::YAW_POS_RST
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  update,
   input  logic [ltrk_pkg::GAIN_W+SAMPLE_BITS:0] mag,
   input  ltrk_pkg::step_flags_type              flags,
   input  logic [ltrk_pkg::POS_W-1:0]            pulse_min,
   input  logic [ltrk_pkg::POS_W-1:0]            pulse_max,
   output logic [ltrk_pkg::POS_W-1:0]            position_ff
);

   localparam int MAG_W  = ltrk_pkg::GAIN_W + SAMPLE_BITS + 1;
   localparam int STEP_W = MAG_W - GAIN_FRAC_BITS;
   localparam int WIDE_W = (STEP_W > ltrk_pkg::POS_W) ? STEP_W + 1 : ltrk_pkg::POS_W + 1;

   logic [STEP_W-1:0]          step;
   logic [WIDE_W-1:0]          step_w;
   logic [WIDE_W-1:0]          pos_w;
   logic [WIDE_W-1:0]          sum_w;
   logic                       blocked;
   logic [ltrk_pkg::POS_W-1:0] moved;
   logic [ltrk_pkg::POS_W-1:0] position_in;

   always_comb begin
      step    = mag[MAG_W-1:GAIN_FRAC_BITS];
      step_w  = WIDE_W'(step);
      pos_w   = WIDE_W'(position_ff);
      sum_w   = pos_w + step_w;
      // dead-zone steps and outward pushes at or beyond a limit are ignored
      blocked = flags.drop ||
                ((position_ff <= pulse_min) && flags.neg) ||
                ((position_ff >= pulse_max) && flags.pos);
      if (flags.neg) begin
         moved = (step_w > pos_w) ? '0 : ltrk_pkg::POS_W'(pos_w - step_w);
      end else begin
         moved = (sum_w > WIDE_W'(ltrk_pkg::POS_MAX)) ? ltrk_pkg::POS_MAX
                                                      : ltrk_pkg::POS_W'(sum_w);
      end
      position_in = blocked ? position_ff : moved;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= RESET_POS;
      end else if (update) begin
         position_ff <= position_in;
      end
   end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the two-axis light tracker servo loop
// ----------------------------------------------------------------------------
// Light ticks go in on the req stream and each one is matched against a pulse
// pair on the rsp stream. A local model of both axes (gain, invert, dead zone,
// outward limits, saturation) works out the pulse pair for every accepted tick
// and keeps it in a queue until the block answers. Directed tests cover sensor
// extremes, saturation at both ends, the outward-limit rule with overshoot, the
// dead zone edge, truncated tiny steps and swapped limits. Random phases then
// reprogram every register and send mostly near-balanced or full-range ticks,
// with bursty idling on both streams.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SAMPLE_BITS  = ltrk_pkg::SAMPLE_BITS_DEF;
   localparam int GAIN_FRAC    = ltrk_pkg::GAIN_FRAC_BITS_DEF;
   localparam int GAIN_W       = ltrk_pkg::GAIN_W;
   localparam int DZ_W         = ltrk_pkg::DZ_W;
   localparam int POS_W        = ltrk_pkg::POS_W;
   localparam int CSR_IDX_W    = ltrk_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W   = ltrk_pkg::CSR_DATA_W;
   localparam int RSP_W        = ltrk_pkg::RSP_TDATA_W;
   localparam int REQ_W        = ((4 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int RAND_PHASES  = 14;
   localparam int PHASE_TICKS  = 110;
   localparam int LIMIT_CYCLES = 200000;

   // one control tick, top right in the lowest bits
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] bottom_left;
      logic [SAMPLE_BITS-1:0] bottom_right;
      logic [SAMPLE_BITS-1:0] top_left;
      logic [SAMPLE_BITS-1:0] top_right;
   } light_tick_type;

   // one answer, yaw in the lowest bits
   typedef struct packed {
      logic [POS_W-1:0] pitch_pulse;
      logic [POS_W-1:0] yaw_pulse;
   } pulse_pair_type;

   typedef struct {
      logic [GAIN_W-1:0] yaw_gain;
      logic [GAIN_W-1:0] pitch_gain;
      logic              yaw_invert;
      logic              pitch_invert;
      logic [DZ_W-1:0]   dead_zone;
      logic [POS_W-1:0]  pulse_max;
      logic [POS_W-1:0]  pulse_min;
   } loop_settings_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // model copy of the registers and of both integrating positions
   loop_settings_type settings;
   logic [POS_W-1:0]  yaw_track_pos;
   logic [POS_W-1:0]  pitch_track_pos;

   pulse_pair_type expected_pulses[$];

   int unsigned ticks_sent;
   int unsigned pulses_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned settings_loaded;
   int unsigned cycle_count = 0;
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;

   two_axis_light_tracker_servo_loop_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, counts every cycle from time zero
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run stopped after %0d cycles, %0d pulse pairs still owed",
                  $time, cycle_count, expected_pulses.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // model of one axis: returns the next position for one light error
   // ---------------------------------------------------------------------------
   function automatic logic [POS_W-1:0] axis_advance(logic [POS_W-1:0] position,
                                                      int light_err,
                                                      logic [GAIN_W-1:0] gain,
                                                      logic invert);
      longint push;
      longint magnitude;
      longint gain_ext;
      longint dz_ext;
      longint target;
      gain_ext = longint'(gain);
      dz_ext   = longint'(settings.dead_zone);
      // error is negated before the gain, invert negates once more
      push = gain_ext * -longint'(light_err);
      if (invert)
         push = -push;
      magnitude = (push < 0) ? -push : push;
      // dead zone looks at the exact step, before truncation
      if (magnitude < (dz_ext << GAIN_FRAC))
         return position;
      // no further outward push once at or past a limit
      if ((position <= settings.pulse_min && push < 0) ||
          (position >= settings.pulse_max && push > 0))
         return position;
      // truncate toward zero, an accepted step may overshoot a limit
      target = longint'(position);
      if (push < 0)
         target = target - (magnitude >>> GAIN_FRAC);
      else
         target = target + (magnitude >>> GAIN_FRAC);
      if (target < 0)
         target = 0;
      if (target > longint'(ltrk_pkg::POS_MAX))
         target = longint'(ltrk_pkg::POS_MAX);
      return target[POS_W-1:0];
   endfunction

   // advances both positions for one tick and gives the pulse pair it leads to
   function automatic pulse_pair_type track_light(light_tick_type t);
      pulse_pair_type pulses;
      int tr;
      int tl;
      int br;
      int bl;
      tr = int'(t.top_right);
      tl = int'(t.top_left);
      br = int'(t.bottom_right);
      bl = int'(t.bottom_left);
      // yaw error is right minus left, pitch error is top minus bottom
      yaw_track_pos   = axis_advance(yaw_track_pos, tr + br - tl - bl,
                                     settings.yaw_gain, settings.yaw_invert);
      pitch_track_pos = axis_advance(pitch_track_pos, tr + tl - br - bl,
                                     settings.pitch_gain, settings.pitch_invert);
      pulses.yaw_pulse   = yaw_track_pos;
      pulses.pitch_pulse = pitch_track_pos;
      return pulses;
   endfunction

   function automatic light_tick_type make_tick(int tr, int tl, int br, int bl);
      light_tick_type t;
      t.top_right    = SAMPLE_BITS'(tr);
      t.top_left     = SAMPLE_BITS'(tl);
      t.bottom_right = SAMPLE_BITS'(br);
      t.bottom_left  = SAMPLE_BITS'(bl);
      return t;
   endfunction

   // random tick: full range, near balance, rail values or one bright sensor
   function automatic light_tick_type random_tick();
      int sample[4];
      int base;
      int spread;
      int mode;
      mode = $urandom_range(0, 9);
      base = $urandom_range(0, SAMPLE_MAX);
      case ($urandom_range(0, 2))
         0: spread = 2;
         1: spread = 16;
         default: spread = 96;
      endcase
      for (int i = 0; i < 4; i++) begin
         if (mode < 4) begin
            sample[i] = $urandom_range(0, SAMPLE_MAX);
         end else if (mode < 8) begin
            // near balance keeps the steps small, so dead zone and truncation matter
            sample[i] = base + $urandom_range(0, 2 * spread) - spread;
            if (sample[i] < 0)
               sample[i] = 0;
            if (sample[i] > SAMPLE_MAX)
               sample[i] = SAMPLE_MAX;
         end else if (mode == 8) begin
            sample[i] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
         end else begin
            sample[i] = $urandom_range(0, SAMPLE_MAX / 8);
         end
      end
      if (mode == 9)
         sample[$urandom_range(0, 3)] = $urandom_range(SAMPLE_MAX / 2, SAMPLE_MAX);
      return make_tick(sample[0], sample[1], sample[2], sample[3]);
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? {GAIN_W{1'b1}} : '0;
         1: return GAIN_W'($urandom_range(0, 1023));
         2: return GAIN_W'($urandom_range(0, 8191));
         3: return GAIN_W'($urandom_range(1024, 24575));
         default: return GAIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic loop_settings_type random_settings();
      loop_settings_type s;
      int lo;
      int hi;
      s.yaw_gain     = random_gain();
      s.pitch_gain   = random_gain();
      s.yaw_invert   = 1'($urandom_range(0, 1));
      s.pitch_invert = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: s.dead_zone = '0;
         1: s.dead_zone = {DZ_W{1'b1}};
         2: s.dead_zone = DZ_W'($urandom_range(0, 20));
         default: s.dead_zone = DZ_W'($urandom_range(0, 255));
      endcase
      lo = $urandom_range(300, 2000);
      hi = $urandom_range(2000, 3800);
      case ($urandom_range(0, 5))
         0: begin
            // full travel
            lo = 0;
            hi = int'(ltrk_pkg::POS_MAX);
         end
         1: begin
            // swapped limits
            int keep;
            keep = lo;
            lo = hi;
            hi = keep;
         end
         2: hi = lo + $urandom_range(0, 40);
         default: ;
      endcase
      s.pulse_min = POS_W'(lo);
      s.pulse_max = POS_W'(hi);
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // stream and register drivers
   // ---------------------------------------------------------------------------

   // register write; csr_valid is left high so back-to-back writes never toggle it
   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_index  <= index;
      csr_wdata  <= value;
      csr_valid  <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // waits until every owed pulse pair is back and the pipeline has emptied
   task automatic drain_pipeline();
      while (expected_pulses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(loop_settings_type s);
      req_tvalid <= 1'b0;
      drain_pipeline();
      csr_write(ltrk_pkg::CSR_YAW_GAIN, CSR_DATA_W'(s.yaw_gain));
      csr_write(ltrk_pkg::CSR_PITCH_GAIN, CSR_DATA_W'(s.pitch_gain));
      csr_write(ltrk_pkg::CSR_YAW_INVERT, CSR_DATA_W'(s.yaw_invert));
      csr_write(ltrk_pkg::CSR_PITCH_INVERT, CSR_DATA_W'(s.pitch_invert));
      csr_write(ltrk_pkg::CSR_DEAD_ZONE, CSR_DATA_W'(s.dead_zone));
      csr_write(ltrk_pkg::CSR_PULSE_MAX, CSR_DATA_W'(s.pulse_max));
      csr_write(ltrk_pkg::CSR_PULSE_MIN, CSR_DATA_W'(s.pulse_min));
      csr_valid <= 1'b0;
      settings = s;
      settings_loaded++;
   endtask

   // one tick transfer; valid stays up unless an idle burst follows
   task automatic send_tick(light_tick_type t);
      req_tdata  <= REQ_W'(t);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_pulses.push_back(track_light(t));
      ticks_sent++;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------------
   // rsp side: random stall bursts and the check against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      pulse_pair_type got;
      pulse_pair_type want;
      int unsigned    stall_left;
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pulses.size() == 0) begin
               mismatch_count++;
               $display("%0t: pulse transfer with nothing owed: expected none actual %h",
                        $time, got);
            end else begin
               want = expected_pulses.pop_front();
               if (got.yaw_pulse !== want.yaw_pulse) begin
                  mismatch_count++;
                  $display("%0t: yaw_pulse expected %0d actual %0d",
                           $time, want.yaw_pulse, got.yaw_pulse);
               end
               if (got.pitch_pulse !== want.pitch_pulse) begin
                  mismatch_count++;
                  $display("%0t: pitch_pulse expected %0d actual %0d",
                           $time, want.pitch_pulse, got.pitch_pulse);
               end
               pulses_checked++;
            end
         end
         // random stall bursts
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset register values, dark, full light and each sensor alone
   task automatic test_reset_values();
      send_tick(make_tick(0, 0, 0, 0));
      send_tick(make_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
      send_tick(make_tick(SAMPLE_MAX, 0, 0, 0));
      send_tick(make_tick(0, SAMPLE_MAX, 0, 0));
      send_tick(make_tick(0, 0, SAMPLE_MAX, 0));
      send_tick(make_tick(0, 0, 0, SAMPLE_MAX));
   endtask

   // largest gain drives both axes into the 0 and 4095 rails
   task automatic test_saturation();
      loop_settings_type s;
      s = '{yaw_gain: '1, pitch_gain: '1, yaw_invert: 1'b0, pitch_invert: 1'b0,
            dead_zone: '0, pulse_max: ltrk_pkg::POS_MAX, pulse_min: '0};
      load_settings(s);
      send_tick(make_tick(0, SAMPLE_MAX, 0, SAMPLE_MAX));
      send_tick(make_tick(SAMPLE_MAX, 0, SAMPLE_MAX, 0));
      send_tick(make_tick(SAMPLE_MAX, SAMPLE_MAX, 0, 0));
      // pitch now sits at the lower limit, another downward push is dropped
      send_tick(make_tick(SAMPLE_MAX, SAMPLE_MAX, 0, 0));
      send_tick(make_tick(0, 0, SAMPLE_MAX, SAMPLE_MAX));
   endtask

   // outward pushes are dropped at a limit, inward ones may overshoot the other
   task automatic test_outward_limits();
      loop_settings_type s;
      s = '{yaw_gain: 16'd4096, pitch_gain: 16'd4096, yaw_invert: 1'b0,
            pitch_invert: 1'b0, dead_zone: '0, pulse_max: 12'd1600, pulse_min: 12'd1400};
      load_settings(s);
      send_tick(make_tick(SAMPLE_MAX, 0, SAMPLE_MAX, 0));
      send_tick(make_tick(0, SAMPLE_MAX, 0, SAMPLE_MAX));
      send_tick(make_tick(0, SAMPLE_MAX, 0, SAMPLE_MAX));
      send_tick(make_tick(600, 0, 600, 0));
      send_tick(make_tick(0, 0, SAMPLE_MAX, SAMPLE_MAX));
      send_tick(make_tick(500, 500, 0, 0));
   endtask

   // steps well under, at and just below the dead zone edge
   task automatic test_dead_zone();
      loop_settings_type s;
      s = '{yaw_gain: 16'd4096, pitch_gain: 16'd4096, yaw_invert: 1'b0,
            pitch_invert: 1'b1, dead_zone: '1, pulse_max: ltrk_pkg::POS_MAX,
            pulse_min: '0};
      load_settings(s);
      send_tick(make_tick(200, 0, 0, 0));
      send_tick(make_tick(255, 0, 0, 0));
      send_tick(make_tick(254, 0, 0, 0));
   endtask

   // nonzero exact step that truncates to nothing, and a zero gain
   task automatic test_tiny_step();
      loop_settings_type s;
      s = '{yaw_gain: 16'd1, pitch_gain: '0, yaw_invert: 1'b1, pitch_invert: 1'b0,
            dead_zone: '0, pulse_max: ltrk_pkg::POS_MAX, pulse_min: '0};
      load_settings(s);
      send_tick(make_tick(0, SAMPLE_MAX, 0, SAMPLE_MAX));
   endtask

   // pulse_min above pulse_max: both rules apply exactly as written
   task automatic test_swapped_limits();
      loop_settings_type s;
      s = '{yaw_gain: 16'd4096, pitch_gain: 16'd4096, yaw_invert: 1'b0,
            pitch_invert: 1'b0, dead_zone: '0, pulse_max: 12'd1000, pulse_min: 12'd3000};
      load_settings(s);
      send_tick(make_tick(300, 0, 300, 0));
      send_tick(make_tick(0, 300, 0, 300));
   endtask

   // two fixed corner phases, then random settings per phase; the last phase runs with no idling at all
   task automatic test_random_tracking();
      loop_settings_type s;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase == 0)
            s = '{yaw_gain: '1, pitch_gain: '1, yaw_invert: 1'b1, pitch_invert: 1'b1,
                  dead_zone: '1, pulse_max: ltrk_pkg::POS_MAX, pulse_min: '0};
         else if (phase == 1)
            s = '{yaw_gain: '0, pitch_gain: '0, yaw_invert: 1'b0, pitch_invert: 1'b0,
                  dead_zone: '0, pulse_max: '0, pulse_min: ltrk_pkg::POS_MAX};
         else
            s = random_settings();
         load_settings(s);
         if (phase == RAND_PHASES - 1) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: req_idle_pct = 0;
               1: req_idle_pct = 15;
               default: req_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: rsp_stall_pct = 0;
               1: rsp_stall_pct = 15;
               default: rsp_stall_pct = 40;
            endcase
         end
         for (int n = 0; n < PHASE_TICKS; n++)
            send_tick(random_tick());
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      ticks_sent     = 0;
      settings_loaded = 0;
      req_idle_pct   = 20;
      rsp_stall_pct  = 20;
      // model starts from the reset register values and positions
      settings = '{yaw_gain: ltrk_pkg::YAW_GAIN_RST, pitch_gain: ltrk_pkg::PITCH_GAIN_RST,
                   yaw_invert: ltrk_pkg::YAW_INVERT_RST,
                   pitch_invert: ltrk_pkg::PITCH_INVERT_RST,
                   dead_zone: ltrk_pkg::DEAD_ZONE_RST, pulse_max: ltrk_pkg::PULSE_MAX_RST,
                   pulse_min: ltrk_pkg::PULSE_MIN_RST};
      yaw_track_pos   = ltrk_pkg::YAW_POS_RST;
      pitch_track_pos = ltrk_pkg::PITCH_POS_RST;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_saturation();
      test_outward_limits();
      test_dead_zone();
      test_tiny_step();
      test_swapped_limits();
      test_random_tracking();

      // let everything owed come back, then watch for stray transfers
      drain_pipeline();
      repeat (10) @(posedge clock);

      $display("tracked %0d light ticks under %0d register settings, %0d pulse pairs checked",
               ticks_sent, settings_loaded, pulses_checked);
      $display("covered rails, outward limits, dead zone edge, tiny steps and swapped limits");
      if (mismatch_count == 0 && expected_pulses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: two_axis_light_tracker_servo_loop_top.f
sv/ltrk_pkg.sv
sv/ltrk_step_calc.sv
sv/ltrk_axis.sv
sv/two_axis_light_tracker_servo_loop_top.sv
dv/testbench.sv
